### hw/rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types and constants of the adaptive Morse timing classifier.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int EST_W  = 12;
    localparam int WPM_W  = 11;
    localparam int DIV_W  = 13;
    localparam int CFG_W  = 12;

    typedef logic [1:0] t_op;
    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_KEY     = 2'd1;
    localparam t_op OP_RESTART = 2'd2;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_DIT_FLOOR = 1'b0;
    localparam t_cfg_idx CFG_INIT_EST  = 1'b1;

    localparam logic [EST_W-1:0] DIT_FLOOR_RST = 12'd60;
    localparam logic [EST_W-1:0] INIT_EST_RST  = 12'd1000;

    localparam int WORD_GAP_X2 = 13;
    localparam int CHAR_GAP_X2 = 7;
    localparam int DASH_X2     = 5;

    localparam logic [DIV_W-1:0] WPM_NUM_X2   = 13'd2400;
    localparam logic [WPM_W-1:0] WPM_ZERO_EST = 11'd1200;
    localparam int               DIV_STEPS    = DIV_W;

    typedef enum logic [1:0] {
        MARK_DOT  = 2'd0,
        MARK_DASH = 2'd1,
        MARK_CHAR = 2'd2,
        MARK_WORD = 2'd3
    } t_mark;

    typedef struct packed {
        t_mark            mark;
        logic [EST_W-1:0] est;
    } t_qent;

endpackage

### hw/rtl/mpc_front.sv
// ----------------------------------------------------------------------------
// mpc_front
// Accepts requests, keeps timer, key state and dit estimate, classifies marks.
// ----------------------------------------------------------------------------
module mpc_front
    import mpc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_acc,
    input  t_op              i_op,
    input  logic             i_key_on,
    output logic             o_push,
    output t_qent            o_push_data
);

    localparam int CMP_W = ((TIMER_BITS > EST_W) ? TIMER_BITS : EST_W) + 5;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [EST_W-1:0]      r_floor;
    logic [EST_W-1:0]      r_init;
    logic [TIMER_BITS-1:0] r_elapsed;
    logic                  r_last_key;
    logic [EST_W-1:0]      r_min;

    logic [CMP_W-1:0]      t_ext;
    logic [CMP_W-1:0]      t_x2;
    logic [EST_W-1:0]      lowered;
    logic [EST_W-1:0]      on_min;
    logic [CMP_W-1:0]      on_min_ext;
    logic [CMP_W-1:0]      min_ext;
    logic                  word_gap;
    logic                  char_gap;
    logic                  is_dash;
    logic                  n_push;

    assign t_ext      = CMP_W'(r_elapsed);
    assign t_x2       = t_ext << 1;
    assign min_ext    = CMP_W'(r_min);
    assign lowered    = (t_ext[EST_W-1:0] < r_floor) ? r_floor : t_ext[EST_W-1:0];
    assign on_min     = (t_ext < min_ext) ? lowered : r_min;
    assign on_min_ext = CMP_W'(on_min);

    assign word_gap = (t_x2 > on_min_ext * CMP_W'(WORD_GAP_X2));
    assign char_gap = (t_x2 > on_min_ext * CMP_W'(CHAR_GAP_X2));
    assign is_dash  = (t_x2 > min_ext * CMP_W'(DASH_X2));
    assign n_push   = i_acc && (i_op == OP_KEY)
                      && (!i_key_on || ((i_key_on != r_last_key) && (word_gap || char_gap)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor    <= DIT_FLOOR_RST;
            r_init     <= INIT_EST_RST;
            r_elapsed  <= '0;
            r_last_key <= 1'b0;
            r_min      <= INIT_EST_RST;
            o_push     <= 1'b0;
        end else begin
            o_push <= n_push;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DIT_FLOOR: r_floor <= i_cfg_wdata;
                    CFG_INIT_EST:  r_init  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_acc) begin
                unique case (i_op)
                    OP_TICK: begin
                        if (r_elapsed != TIMER_MAX) r_elapsed <= r_elapsed + 1'b1;
                    end
                    OP_RESTART: begin
                        r_min     <= r_init;
                        r_elapsed <= '0;
                    end
                    OP_KEY: begin
                        r_last_key <= i_key_on;
                        if (i_key_on != r_last_key) begin
                            r_elapsed <= '0;
                            if (i_key_on) begin
                                r_min <= on_min;
                                o_push_data.est <= on_min;
                                if (word_gap) begin
                                    o_push_data.mark <= MARK_WORD;
                                end else if (char_gap) begin
                                    o_push_data.mark <= MARK_CHAR;
                                end
                            end else begin
                                o_push_data.est  <= r_min;
                                o_push_data.mark <= is_dash ? MARK_DASH : MARK_DOT;
                            end
                        end else if (!i_key_on) begin
                            o_push_data.est  <= r_min;
                            o_push_data.mark <= MARK_WORD;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

### hw/rtl/mpc_queue.sv
// ----------------------------------------------------------------------------
// mpc_queue
// Two-entry queue of classified marks between front and back.
// ----------------------------------------------------------------------------
module mpc_queue
    import mpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_push_data,
    input  logic  i_pop,
    output t_qent o_pop_data,
    output logic  o_empty,
    output logic  o_full
);

    t_qent       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_empty    = (r_cnt == 2'd0);
    assign o_full     = (r_cnt == 2'd2);
    assign o_pop_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/mpc_back.sv
// ----------------------------------------------------------------------------
// mpc_back
// Pops marks, computes rounded WPM with a restoring divider, drives results.
// ----------------------------------------------------------------------------
module mpc_back
    import mpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_qent            i_pop_data,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [1:0]       o_mark,
    output logic [WPM_W-1:0] o_wpm,
    output logic [EST_W-1:0] o_dit_estimate_ms
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_state           r_state;
    t_mark            r_mark;
    logic [EST_W-1:0] r_est;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;

    logic [DIV_W:0]   rem_sh;
    logic             q_bit;
    logic             out_free;

    assign rem_sh   = {r_rem, r_num[DIV_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_den});
    assign out_free = !o_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_HOLD)) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_mark  <= i_pop_data.mark;
                        r_est   <= i_pop_data.est;
                        r_num   <= WPM_NUM_X2 + DIV_W'(i_pop_data.est);
                        r_den   <= {i_pop_data.est, 1'b0};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? DIV_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], q_bit};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        o_valid           <= 1'b1;
                        o_mark            <= r_mark;
                        o_wpm             <= (r_est == '0) ? WPM_ZERO_EST : r_quo[WPM_W-1:0];
                        o_dit_estimate_ms <= r_est;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/morse_pulse_classifier.sv
// ----------------------------------------------------------------------------
// morse_pulse_classifier
// Adaptive Morse timing classifier: dot, dash, character and word gaps.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries requests: millisecond ticks, key
// state reports and estimate restarts. The front stage takes one request per
// cycle while its two-entry mark queue has room, updates timer, key state and
// dit estimate, and queues a mark when the request yields one.
// Output channel (o_valid / i_stall) returns mark, rounded WPM and the dit
// estimate. Each result passes through a 13-step restoring divider in the
// back stage, which takes the next mark from the queue only after the result
// before it has been loaded into the output register.
// Ticks and other requests with no result never reach the queue.
// A stalled receiver holds the output register; the back stage waits, the
// queue fills, and then o_stall rises until a result is taken.
// Reset (i_rst_n low, synchronous) clears timer and key state, loads the dit
// estimate with 1000 ms, the floor with 60 ms, and empties queue and output.
// Config writes (i_cfg_we): one register a cycle, floor now, init at restart.
// ----------------------------------------------------------------------------
module morse_pulse_classifier
    import mpc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_op,
    input  logic             i_key_on,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_mark,
    output logic [WPM_W-1:0] o_wpm,
    output logic [EST_W-1:0] o_dit_estimate_ms
);

    logic  acc;
    logic  push;
    t_qent push_data;
    logic  pop;
    t_qent pop_data;
    logic  q_empty;
    logic  q_full;

    assign o_stall = q_full || (push && !q_empty);
    assign acc     = i_valid && !o_stall;

    mpc_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_op        (i_op),
        .i_key_on    (i_key_on),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mpc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    mpc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_pop_data        (pop_data),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_mark            (o_mark),
        .o_wpm             (o_wpm),
        .o_dit_estimate_ms (o_dit_estimate_ms)
    );

endmodule

### tb/tb_morse_pulse_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_pulse_classifier
// Self-checking bench for the adaptive Morse timing classifier. Drives tick,
// key and restart requests in bursts, predicts each mark with wpm and dit
// estimate in a local timing model, and compares results in arrival order
// while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_morse_pulse_classifier;
    import mpc_pkg::*;

    localparam int  TIMER_BITS   = 16;
    localparam int  TIMER_MAX    = (1 << TIMER_BITS) - 1;
    localparam t_op OP_UNUSED    = 2'd3;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  CYCLE_LIMIT  = 1_000_000;

    typedef struct {
        t_mark            mark;
        logic [WPM_W-1:0] wpm;
        logic [EST_W-1:0] est;
    } t_pending_mark;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_valid;
    logic             o_stall;
    logic [1:0]       i_op;
    logic             i_key_on;
    logic             o_valid;
    logic             i_stall;
    logic [1:0]       o_mark;
    logic [WPM_W-1:0] o_wpm;
    logic [EST_W-1:0] o_dit_estimate_ms;

    t_pending_mark pending_marks[$];

    int   key_timer_ms;
    logic key_state;
    int   dit_est_ms;
    int   floor_ms;
    int   init_ms;

    int   mismatch_count = 0;
    int   sent_count     = 0;
    int   cycle_count    = 0;
    int   burst_left     = 0;
    int   hold_req       = 0;
    int   hold_seen      = 0;
    int   hold_left      = 0;
    int   stall_mode     = 0;
    int   mode_left      = 0;
    int   pat_count      = 0;

    morse_pulse_classifier #(
        .TIMER_BITS(TIMER_BITS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_key_on          (i_key_on),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_mark            (o_mark),
        .o_wpm             (o_wpm),
        .o_dit_estimate_ms (o_dit_estimate_ms)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_morse_pulse_classifier: FAIL");
            $finish;
        end
    end

    // receiver: long hold when asked, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        pat_count++;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= ((pat_count % 11) < 4);
            endcase
        end
    end

    function automatic int wpm_of(input int est);
        if (est == 0)
            return int'(WPM_ZERO_EST);
        return (2400 + est) / (2 * est);
    endfunction

    function automatic void queue_mark(input t_mark m);
        t_pending_mark p;
        p.mark = m;
        p.wpm  = WPM_W'(wpm_of(dit_est_ms));
        p.est  = EST_W'(dit_est_ms);
        pending_marks.push_back(p);
    endfunction

    function automatic void classify_request(input t_op op, input logic key);
        int t;
        t = key_timer_ms;
        case (op)
            OP_TICK: begin
                if (key_timer_ms < TIMER_MAX)
                    key_timer_ms++;
            end
            OP_RESTART: begin
                dit_est_ms   = init_ms;
                key_timer_ms = 0;
            end
            OP_KEY: begin
                if (key != key_state) begin
                    if (key) begin
                        if (t < dit_est_ms) begin
                            dit_est_ms = t;
                            if (dit_est_ms < floor_ms)
                                dit_est_ms = floor_ms;
                        end
                        if (2 * t > WORD_GAP_X2 * dit_est_ms)
                            queue_mark(MARK_WORD);
                        else if (2 * t > CHAR_GAP_X2 * dit_est_ms)
                            queue_mark(MARK_CHAR);
                    end else begin
                        queue_mark((2 * t > DASH_X2 * dit_est_ms) ? MARK_DASH : MARK_DOT);
                    end
                    key_timer_ms = 0;
                end else if (!key) begin
                    queue_mark(MARK_WORD);
                end
                key_state = key;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pending_mark want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_marks.size() == 0) begin
                $display("%0t: unexpected result mark=%0d wpm=%0d est=%0d",
                         $time, o_mark, o_wpm, o_dit_estimate_ms);
                mismatch_count++;
            end else begin
                want = pending_marks.pop_front();
                if (o_mark !== want.mark) begin
                    $display("%0t: mark expected %0d actual %0d", $time, want.mark, o_mark);
                    mismatch_count++;
                end
                if (o_wpm !== want.wpm) begin
                    $display("%0t: wpm expected %0d actual %0d", $time, want.wpm, o_wpm);
                    mismatch_count++;
                end
                if (o_dit_estimate_ms !== want.est) begin
                    $display("%0t: dit estimate expected %0d actual %0d",
                             $time, want.est, o_dit_estimate_ms);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int sender_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        return $urandom_range(1, 7);
    endfunction

    task automatic send_request(input t_op op, input logic key);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_key_on <= key;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        classify_request(op, key);
        sent_count++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DIT_FLOOR)
            floor_ms = value;
        else
            init_ms = value;
        @(posedge i_clk);
    endtask

    task automatic start_phase(input int floor_val, input int init_val);
        wait_idle();
        write_register(CFG_DIT_FLOOR, floor_val);
        write_register(CFG_INIT_EST, init_val);
        send_request(OP_RESTART, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_reset_defaults();
        send_request(OP_KEY, 1'b0);
        send_request(OP_KEY, 1'b1);
        send_request(OP_KEY, 1'b0);
    endtask

    task automatic test_directed_marks();
        start_phase(1, 1);
        send_request(OP_UNUSED, 1'b1);
        send_request(OP_KEY, 1'b0);
        send_request(OP_KEY, 1'b1);
        send_request(OP_KEY, 1'b1);
        send_request(OP_KEY, 1'b0);
        send_ticks(3);
        send_request(OP_KEY, 1'b1);
        send_ticks(3);
        send_request(OP_KEY, 1'b0);
        send_ticks(4);
        send_request(OP_KEY, 1'b1);
        send_request(OP_KEY, 1'b0);
        send_request(OP_RESTART, 1'b1);
    endtask

    task automatic run_keying(input int unit, input int n_items);
        int stop_at;
        int on_len;
        int off_len;
        int pick;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                on_len  = unit * (($urandom_range(0, 1) == 1) ? 3 : 1)
                          + $urandom_range(0, unit) - unit / 2;
                pick    = $urandom_range(0, 2);
                off_len = unit * ((pick == 0) ? 1 : (pick == 1) ? 3 : 7)
                          + $urandom_range(0, unit) - unit / 2;
                send_request(OP_KEY, 1'b1);
                send_ticks(on_len);
                send_request(OP_KEY, 1'b0);
                send_ticks(off_len);
            end else begin
                send_request(t_op'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_keying();
        int f;
        int e;
        start_phase(1, 2);
        run_keying(2, 170);
        start_phase(2, 4);
        run_keying(3, 170);
        start_phase(1, 8);
        run_keying(4, 170);
        start_phase(3, 3);
        run_keying(3, 170);
        f = $urandom_range(1, 4);
        e = $urandom_range(1, 6);
        start_phase(f, e);
        run_keying(e, 170);
        f = $urandom_range(1, 4095);
        e = $urandom_range(1, 4095);
        start_phase(f, e);
        run_keying((e > 6) ? 6 : e, 60);
    endtask

    task automatic test_back_pressure();
        start_phase(1, 1);
        hold_req <= hold_req + 1;
        repeat (20) begin
            send_request(OP_KEY, 1'b1);
            send_ticks($urandom_range(0, 3));
            send_request(OP_KEY, 1'b0);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_DIT_FLOOR;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_op         = OP_TICK;
        i_key_on     = 1'b0;
        i_stall      = 1'b0;
        key_timer_ms = 0;
        key_state    = 1'b0;
        floor_ms     = int'(DIT_FLOOR_RST);
        init_ms      = int'(INIT_EST_RST);
        dit_est_ms   = init_ms;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_marks();
        test_back_pressure();
        test_random_keying();

        wait_idle();
        if (mismatch_count == 0 && pending_marks.size() == 0) begin
            $display("tb_morse_pulse_classifier: PASS");
        end else begin
            $display("tb_morse_pulse_classifier: FAIL");
        end
        $finish;
    end

endmodule
